### sv/vertex_dedup_indexer_macros.svh
// ----------------------------------------------------------------------------
// vertex_dedup_indexer_macros
// assertion macros used by the vdi_back module of the vertex dedup indexer
// ----------------------------------------------------------------------------
`ifndef VERTEX_DEDUP_INDEXER_MACROS_SVH
`define VERTEX_DEDUP_INDEXER_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define VDI_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// condition must never be seen outside reset
`define VDI_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

### sv/vdi_pkg.sv
// ----------------------------------------------------------------------------
// vdi_pkg
// types, constants and compare functions of the vertex dedup indexer
// ----------------------------------------------------------------------------
package vdi_pkg;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = IDX_W + 1;
  localparam int unsigned OUT_IDX_W   = 10;
  localparam int unsigned NUM_COMP    = 9;
  localparam int unsigned VTX_W       = NUM_COMP * 32;

  localparam logic [31:0] ONE_F32 = 32'h3F80_0000;

  localparam int unsigned MASK_POS  = 0;
  localparam int unsigned MASK_TEX  = 1;
  localparam int unsigned MASK_NORM = 2;

  typedef struct packed {
    logic        start_mesh;
    logic [2:0]  present_mask;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] pos_w;
    logic [31:0] tex_u;
    logic [31:0] tex_v;
    logic [31:0] norm_x;
    logic [31:0] norm_y;
    logic [31:0] norm_z;
  } vdi_in_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] vertex_index;
    logic                 is_new;
    logic                 table_full;
  } vdi_out_t;

  typedef logic [VTX_W-1:0] vdi_vtx_t;

  typedef struct packed {
    logic     start_mesh;
    vdi_vtx_t vtx;
  } vdi_corner_t;

  function automatic logic f32_is_nan(logic [31:0] a);
    return a[30:0] > 31'h7F80_0000;
  endfunction

  function automatic logic f32_eq(logic [31:0] a, logic [31:0] b);
    logic r;
    if (f32_is_nan(a) || f32_is_nan(b)) begin
      r = 1'b0;
    end else if ((a[30:0] | b[30:0]) == 31'd0) begin
      r = 1'b1;
    end else begin
      r = (a == b);
    end
    return r;
  endfunction

  function automatic logic vtx_match(vdi_vtx_t a, vdi_vtx_t b);
    logic r;
    r = 1'b1;
    for (int k = 0; k < NUM_COMP; k++) begin
      r = r & f32_eq(a[k*32 +: 32], b[k*32 +: 32]);
    end
    return r;
  endfunction

endpackage

### sv/vdi_ram.sv
// ----------------------------------------------------------------------------
// vdi_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module vdi_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/vdi_front.sv
// ----------------------------------------------------------------------------
// vdi_front
// accepts corners, fills absent attributes with 1.0 and pushes to the queue
// ----------------------------------------------------------------------------
module vdi_front (
  input  logic                 start,
  output logic                 busy,
  input  vdi_pkg::vdi_in_t     in_i,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output vdi_pkg::vdi_corner_t q_data_o
);
  import vdi_pkg::*;

  logic [31:0] px, py, pz, pw, tu, tv, nx, ny, nzc;

  always_comb begin
    px  = in_i.present_mask[MASK_POS]  ? in_i.pos_x  : ONE_F32;
    py  = in_i.present_mask[MASK_POS]  ? in_i.pos_y  : ONE_F32;
    pz  = in_i.present_mask[MASK_POS]  ? in_i.pos_z  : ONE_F32;
    pw  = in_i.present_mask[MASK_POS]  ? in_i.pos_w  : ONE_F32;
    tu  = in_i.present_mask[MASK_TEX]  ? in_i.tex_u  : ONE_F32;
    tv  = in_i.present_mask[MASK_TEX]  ? in_i.tex_v  : ONE_F32;
    nx  = in_i.present_mask[MASK_NORM] ? in_i.norm_x : ONE_F32;
    ny  = in_i.present_mask[MASK_NORM] ? in_i.norm_y : ONE_F32;
    nzc = in_i.present_mask[MASK_NORM] ? in_i.norm_z : ONE_F32;
  end

  assign busy                = q_full_i;
  assign q_push_o            = start && !q_full_i;
  assign q_data_o.start_mesh = in_i.start_mesh;
  assign q_data_o.vtx        = {nzc, ny, nx, tv, tu, pw, pz, py, px};

endmodule

### sv/vdi_queue.sv
// ----------------------------------------------------------------------------
// vdi_queue
// two-entry queue between the front and the search engine
// ----------------------------------------------------------------------------
module vdi_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  vdi_pkg::vdi_corner_t push_data_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output vdi_pkg::vdi_corner_t pop_data_o
);
  import vdi_pkg::*;

  vdi_corner_t slot_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + 2'd1;
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign full_o     = (fill_q == 2'd2);
  assign empty_o    = (fill_q == 2'd0);
  assign pop_data_o = slot_q[rd_ptr_q];

endmodule

### sv/vdi_back.sv
// ----------------------------------------------------------------------------
// vdi_back
// linear search of the unique-vertex table, append on miss while room is left
// ----------------------------------------------------------------------------
`include "vertex_dedup_indexer_macros.svh"

module vdi_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_empty_i,
  input  vdi_pkg::vdi_corner_t q_data_i,
  output logic                 q_pop_o,
  output logic                 valid_o,
  output vdi_pkg::vdi_out_t    res_o
);
  import vdi_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] rd_addr_q, rd_addr_d;
  logic [IDX_W-1:0] cmp_idx_q, cmp_idx_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic             valid_q, valid_d;
  vdi_out_t         res_q, res_d;
  vdi_vtx_t         cur_q, cur_d;

  logic             issue;
  logic             hit;
  logic             ram_we;
  logic [IDX_W-1:0] ram_addr;
  vdi_vtx_t         ram_rdata;

  vdi_ram #(
    .WIDTH (VTX_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (cur_q),
    .rdata_o (ram_rdata)
  );

  assign issue = (state_q == ST_SEARCH) && (rd_addr_q < cnt_q);
  assign hit   = cmp_vld_q && vtx_match(ram_rdata, cur_q);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    rd_addr_d = rd_addr_q;
    cmp_idx_d = cmp_idx_q;
    cmp_vld_d = 1'b0;
    valid_d   = 1'b0;
    res_d     = res_q;
    cur_d     = cur_q;
    q_pop_o   = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = rd_addr_q[IDX_W-1:0];
    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o   = 1'b1;
          cur_d     = q_data_i.vtx;
          rd_addr_d = '0;
          if (q_data_i.start_mesh) begin
            cnt_d = '0;
          end
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (hit) begin
          valid_d = 1'b1;
          res_d   = '{vertex_index: OUT_IDX_W'(cmp_idx_q), is_new: 1'b0, table_full: 1'b0};
          state_d = ST_IDLE;
        end else if (!issue && !cmp_vld_q) begin
          valid_d = 1'b1;
          state_d = ST_IDLE;
          if (cnt_q == CNT_W'(TABLE_DEPTH)) begin
            res_d = '{vertex_index: '0, is_new: 1'b0, table_full: 1'b1};
          end else begin
            ram_we   = 1'b1;
            ram_addr = cnt_q[IDX_W-1:0];
            res_d    = '{vertex_index: OUT_IDX_W'(cnt_q[IDX_W-1:0]), is_new: 1'b1,
                         table_full: 1'b0};
            cnt_d    = cnt_q + CNT_W'(1);
          end
        end else if (issue) begin
          rd_addr_d = rd_addr_q + CNT_W'(1);
          cmp_vld_d = 1'b1;
          cmp_idx_d = rd_addr_q[IDX_W-1:0];
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      rd_addr_q <= '0;
      cmp_vld_q <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rd_addr_q <= rd_addr_d;
      cmp_vld_q <= cmp_vld_d;
      valid_q   <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= cmp_idx_d;
    res_q     <= res_d;
    cur_q     <= cur_d;
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

  `VDI_ASSERT_NEVER(a_new_and_full, clk_i, rst_ni, valid_q && res_q.is_new && res_q.table_full, "result both new and full")
  `VDI_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q <= CNT_W'(TABLE_DEPTH), "vertex count beyond table depth")
  `VDI_ASSERT(a_new_cnt, clk_i, rst_ni, (valid_q && res_q.is_new) |-> (cnt_q[IDX_W-1:0] == IDX_W'(res_q.vertex_index) + IDX_W'(1)), "appended index does not match count")
  `VDI_ASSERT(a_full_cnt, clk_i, rst_ni, (valid_q && res_q.table_full) |-> (cnt_q == CNT_W'(TABLE_DEPTH) && res_q.vertex_index == '0), "full flagged with room left")
  `VDI_ASSERT(a_pop_idle, clk_i, rst_ni, q_pop_o |-> (state_q == ST_IDLE && !q_empty_i), "pop outside idle")

endmodule

### sv/vertex_dedup_indexer.sv
// ----------------------------------------------------------------------------
// vertex_dedup_indexer
// deduplicating vertex table that returns an index buffer entry per corner
//
//   channel  | signals                | handshake
//   ---------+------------------------+-----------------------------------
//   corner   | start, busy, in_i      | transfer when start && !busy
//   result   | valid_o, res_o         | one-cycle strobe, no back-pressure
//
// search engine: a pop from the queue, then one table ram read per stored entry
// a hit on entry j returns j, a miss on n stored entries appends at index n
// (table_full instead when the table is full); the result strobe is registered
// up to two corners wait in the queue; busy is high while it is full
// results cannot be held off
// reset clears the vertex count; the table ram needs no clearing pass
// ----------------------------------------------------------------------------
module vertex_dedup_indexer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  vdi_pkg::vdi_in_t  in_i,
  output logic              valid_o,
  output vdi_pkg::vdi_out_t res_o
);
  import vdi_pkg::*;

  logic        q_full, q_push, q_pop, q_empty;
  vdi_corner_t q_in, q_out;

  vdi_front u_front (
    .start    (start),
    .busy     (busy),
    .in_i     (in_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_data_o (q_in)
  );

  vdi_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_data_o  (q_out)
  );

  vdi_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_data_i  (q_out),
    .q_pop_o   (q_pop),
    .valid_o   (valid_o),
    .res_o     (res_o)
  );

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the vertex dedup indexer: corners are driven with
// random start gaps, each accepted corner updates a local copy of the unique
// vertex table, and every result strobe is compared with the predicted index,
// new flag and full flag
// ----------------------------------------------------------------------------
module tb_top;
  import vdi_pkg::*;

  localparam logic [31:0] F32_POS_ZERO = 32'h0000_0000;
  localparam logic [31:0] F32_NEG_ZERO = 32'h8000_0000;
  localparam logic [31:0] F32_POS_INF  = 32'h7F80_0000;
  localparam logic [31:0] F32_NEG_INF  = 32'hFF80_0000;
  localparam logic [31:0] F32_MIN_NAN  = 32'h7F80_0001;
  localparam logic [31:0] F32_QNAN     = 32'h7FC0_0000;
  localparam logic [31:0] F32_ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [31:0] F32_PI       = 32'h4049_0FDB;
  localparam logic [31:0] F32_HALF     = 32'h3F00_0000;
  localparam logic [31:0] F32_POS_DEN  = 32'h0000_0001;
  localparam logic [31:0] F32_NEG_DEN  = 32'h8000_0001;

  class index_scoreboard;
    bit [31:0]   unique_vtx [TABLE_DEPTH][NUM_COMP];
    int unsigned unique_cnt;
    vdi_out_t    expected_idx_q [$];
    int unsigned n_errors;

    function void flag(string msg);
      n_errors++;
      if (n_errors <= 10) begin
        $display("%s", msg);
      end
    endfunction

    function bit same_float(bit [31:0] a, bit [31:0] b);
      bit a_nan;
      bit b_nan;
      a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
      b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
      if (a_nan || b_nan) begin
        return 1'b0;
      end
      if (a[30:0] == 31'd0 && b[30:0] == 31'd0) begin
        return 1'b1;
      end
      return a == b;
    endfunction

    function void note_corner(vdi_in_t c);
      bit [31:0]   comp [NUM_COMP];
      vdi_out_t    res;
      bit          hit;
      bit          same;
      int unsigned found;
      comp = '{c.pos_x, c.pos_y, c.pos_z, c.pos_w, c.tex_u, c.tex_v,
               c.norm_x, c.norm_y, c.norm_z};
      // absent attributes read as 1.0
      if (!c.present_mask[MASK_POS]) begin
        for (int k = 0; k < 4; k++) comp[k] = ONE_F32;
      end
      if (!c.present_mask[MASK_TEX]) begin
        for (int k = 4; k < 6; k++) comp[k] = ONE_F32;
      end
      if (!c.present_mask[MASK_NORM]) begin
        for (int k = 6; k < 9; k++) comp[k] = ONE_F32;
      end
      if (c.start_mesh) begin
        unique_cnt = 0;
      end
      hit   = 1'b0;
      found = 0;
      for (int unsigned i = 0; i < unique_cnt && !hit; i++) begin
        same = 1'b1;
        for (int k = 0; k < NUM_COMP; k++) begin
          same &= same_float(unique_vtx[i][k], comp[k]);
        end
        if (same) begin
          hit   = 1'b1;
          found = i;
        end
      end
      res = '0;
      if (hit) begin
        res.vertex_index = OUT_IDX_W'(found);
      end else if (unique_cnt == TABLE_DEPTH) begin
        res.table_full = 1'b1;
      end else begin
        unique_vtx[unique_cnt] = comp;
        res.vertex_index       = OUT_IDX_W'(unique_cnt);
        res.is_new             = 1'b1;
        unique_cnt++;
      end
      expected_idx_q = {expected_idx_q, res};
    endfunction

    function void check_result(vdi_out_t got);
      vdi_out_t exp_res;
      if (expected_idx_q.size() == 0) begin
        flag($sformatf("unexpected result: idx %0d new %0b full %0b",
                       got.vertex_index, got.is_new, got.table_full));
        return;
      end
      exp_res = expected_idx_q.pop_front();
      if (got.vertex_index !== exp_res.vertex_index || got.is_new !== exp_res.is_new ||
          got.table_full !== exp_res.table_full) begin
        flag($sformatf("result mismatch: expected idx %0d new %0b full %0b, got idx %0d new %0b full %0b",
                       exp_res.vertex_index, exp_res.is_new, exp_res.table_full,
                       got.vertex_index, got.is_new, got.table_full));
      end
    endfunction

    function int unsigned pending();
      return expected_idx_q.size();
    endfunction

    function void close();
      while (expected_idx_q.size() != 0) begin
        void'(expected_idx_q.pop_front());
        flag("result never arrived");
      end
    endfunction
  endclass

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     start;
  logic     busy;
  vdi_in_t  in_i;
  logic     valid_o;
  vdi_out_t res_o;

  index_scoreboard sb = new();
  vdi_in_t         mesh_q [$];
  bit              idle_on = 1'b1;

  vertex_dedup_indexer uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .in_i    (in_i),
    .valid_o (valid_o),
    .res_o   (res_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        sb.note_corner(in_i);
      end
      if (valid_o) begin
        sb.check_result(res_o);
      end
    end
  end

  function automatic logic [31:0] pick_float();
    logic [31:0] f;
    case ($urandom_range(0, 11))
      0: f = F32_POS_ZERO;
      1: f = F32_NEG_ZERO;
      2: f = ONE_F32;
      3: f = {1'($urandom_range(0, 1)), 8'hFF, 23'($urandom_range(1, 23'h7F_FFFF))};
      4: f = {1'($urandom_range(0, 1)), 8'hFF, 23'd0};
      5: f = {1'($urandom_range(0, 1)), 8'h00, 23'($urandom())};
      6: f = F32_HALF;
      default: f = $urandom();
    endcase
    return f;
  endfunction

  function automatic vdi_in_t fresh_corner(bit wild);
    vdi_in_t          c;
    logic [8:0][31:0] w;
    for (int k = 0; k < NUM_COMP; k++) begin
      w[k] = wild ? pick_float() : 32'($urandom());
    end
    c                = '0;
    c[VTX_W-1:0]     = w;
    c.present_mask   = wild ? 3'($urandom_range(0, 7)) : 3'b111;
    return c;
  endfunction

  function automatic vdi_in_t repeat_corner();
    vdi_in_t          c;
    logic [8:0][31:0] w;
    c            = mesh_q[$urandom_range(0, mesh_q.size() - 1)];
    c.start_mesh = 1'b0;
    w            = c[VTX_W-1:0];
    // absent attributes may carry any junk
    if (!c.present_mask[MASK_POS]) begin
      for (int k = 5; k < 9; k++) w[k] = $urandom();
    end
    if (!c.present_mask[MASK_TEX]) begin
      for (int k = 3; k < 5; k++) w[k] = $urandom();
    end
    if (!c.present_mask[MASK_NORM]) begin
      for (int k = 0; k < 3; k++) w[k] = $urandom();
    end
    for (int k = 0; k < NUM_COMP; k++) begin
      if (w[k][30:0] == 31'd0 && $urandom_range(0, 1) != 0) begin
        w[k][31] = ~w[k][31];
      end
    end
    // near miss on one component
    if ($urandom_range(0, 5) == 0) begin
      w[$urandom_range(0, 8)] = pick_float();
    end
    c[VTX_W-1:0] = w;
    return c;
  endfunction

  function automatic vdi_in_t uniform_corner(logic s, logic [2:0] m, logic [31:0] f);
    vdi_in_t c;
    c = {s, m, {NUM_COMP{f}}};
    return c;
  endfunction

  task automatic drive_corner(input vdi_in_t c);
    start <= 1'b1;
    in_i  <= c;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic idle_cycles(input int unsigned n);
    start <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic maybe_idle();
    if ($urandom_range(0, 39) == 0) begin
      idle_on = !idle_on;
    end
    if (idle_on && $urandom_range(0, 4) == 0) begin
      idle_cycles($urandom_range(1, 19));
    end
  endtask

  task automatic send_directed(input vdi_in_t c);
    drive_corner(c);
    maybe_idle();
  endtask

  task automatic directed_corners();
    vdi_in_t c;
    send_directed(uniform_corner(1'b1, 3'b111, F32_POS_ZERO));
    send_directed(uniform_corner(1'b0, 3'b111, F32_NEG_ZERO));
    send_directed(uniform_corner(1'b0, 3'b111, F32_ALL_ONES));
    send_directed(uniform_corner(1'b0, 3'b111, F32_ALL_ONES));
    send_directed(uniform_corner(1'b0, 3'b000, 32'h1234_5678));
    send_directed(uniform_corner(1'b0, 3'b000, F32_POS_ZERO));
    send_directed(uniform_corner(1'b0, 3'b111, ONE_F32));
    send_directed(uniform_corner(1'b0, 3'b001, F32_PI));
    c       = uniform_corner(1'b0, 3'b011, F32_PI);
    c.tex_u = ONE_F32;
    c.tex_v = ONE_F32;
    send_directed(c);
    send_directed(uniform_corner(1'b0, 3'b010, F32_PI));
    send_directed(uniform_corner(1'b0, 3'b100, F32_PI));
    send_directed(uniform_corner(1'b0, 3'b110, F32_PI));
    send_directed(uniform_corner(1'b0, 3'b101, F32_PI));
    send_directed(uniform_corner(1'b0, 3'b111, F32_POS_INF));
    send_directed(uniform_corner(1'b0, 3'b111, F32_NEG_INF));
    send_directed(uniform_corner(1'b0, 3'b111, F32_POS_INF));
    send_directed(uniform_corner(1'b0, 3'b111, F32_MIN_NAN));
    c        = uniform_corner(1'b0, 3'b111, F32_POS_ZERO);
    c.norm_z = F32_QNAN;
    send_directed(c);
    send_directed(c);
    send_directed(uniform_corner(1'b0, 3'b111, 32'h7FFF_FFFF));
    send_directed(uniform_corner(1'b0, 3'b111, F32_POS_DEN));
    send_directed(uniform_corner(1'b0, 3'b111, F32_NEG_DEN));
    send_directed(uniform_corner(1'b1, 3'b111, F32_NEG_ZERO));
    send_directed(uniform_corner(1'b1, 3'b111, F32_POS_ZERO));
    send_directed(uniform_corner(1'b0, 3'b111, F32_NEG_ZERO));
  endtask

  task automatic run_meshes(input int unsigned n_items, input int unsigned quiet_tail);
    vdi_in_t c;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (mesh_q.size() == 0 || $urandom_range(0, 24) == 0) begin
        c = (mesh_q.size() != 0 && $urandom_range(0, 2) == 0) ?
            repeat_corner() : fresh_corner(1'b1);
        c.start_mesh = 1'b1;
        mesh_q.delete();
      end else if ($urandom_range(0, 9) < 6) begin
        c = repeat_corner();
      end else begin
        c = fresh_corner($urandom_range(0, 3) != 0);
      end
      mesh_q = {mesh_q, c};
      drive_corner(c);
      if (i + quiet_tail < n_items) begin
        maybe_idle();
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start  = 1'b0;
    in_i   = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    directed_corners();
    run_meshes(300, 0);
    run_meshes(250, 80);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (1100) @(posedge clk_i);
    sb.close();
    if (sb.n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("timeout with %0d results outstanding", sb.pending());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/vdi_pkg.sv
sv/vdi_ram.sv
sv/vdi_front.sv
sv/vdi_queue.sv
sv/vdi_back.sv
sv/vertex_dedup_indexer.sv
tb/tb_top.sv
